FILE: hdl/assert_macros.svh
// Assertion helper macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/f8cv_pkg.sv
// ----------------------------------------------------------------------------
// f8cv_pkg
// Types and constants shared by the FP32 / FP8 converter.
// ----------------------------------------------------------------------------
`default_nettype none
package f8cv_pkg;

  typedef enum logic {
    FMT_E4M3 = 1'b0,
    FMT_E5M2 = 1'b1
  } fmt_e;

  typedef enum logic {
    ACT_QUANT  = 1'b0,
    ACT_EXPAND = 1'b1
  } act_e;

  typedef struct packed {
    logic        action;
    logic [31:0] fp32_in;
    logic [7:0]  fp8_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  fp8_out;
    logic [31:0] fp32_out;
  } rsp_t;

  localparam logic [7:0]  Fp8NanCode    = 8'h7F;
  localparam logic [7:0]  E4m3InfCode   = 8'h7E;
  localparam logic [7:0]  E5m2InfCode   = 8'h7B;
  localparam logic [30:0] Fp32InfMag    = 31'h7F800000;
  localparam logic [30:0] E4m3MaxMag    = 31'h43E00000;
  localparam logic [30:0] E5m2MaxMag    = 31'h47600000;

endpackage
`default_nettype wire

FILE: hdl/f8cv_if.sv
// ----------------------------------------------------------------------------
// f8cv_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface f8cv_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/f8cv_cfg_if.sv
// ----------------------------------------------------------------------------
// f8cv_cfg_if
// Configuration write channel for the format register.
// ----------------------------------------------------------------------------
`default_nettype none
interface f8cv_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/fp32_fp8_converter.sv
// ----------------------------------------------------------------------------
// fp32_fp8_converter
// Converts FP32 to FP8 (E4M3 or E5M2) and back, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Each input word is registered, converted by short combinational logic and
// held in a result register. A new word is accepted every cycle while the
// input register is empty or moving on into the result register, and the
// result register moves on while it is empty or being drained, so the
// throughput is one word per clock. After the accept the word waits in the input
// register and is loaded into the result register when that register advances,
// so a stall at the output can hold it in the input register.
`default_nettype none
`include "assert_macros.svh"
module fp32_fp8_converter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  f8cv_cfg_if.sink  cfg_i,
  f8cv_if.sink      in_i,
  f8cv_if.source    out_o
);
  import f8cv_pkg::*;

  logic fmt_q;
  logic in_vld_q, out_vld_q;
  req_t in_q;
  rsp_t out_q, res_d;
  logic adv_out, adv_in;

  assign cfg_i.ready = 1'b1;
  assign adv_out     = !out_vld_q || out_o.ready;
  assign adv_in      = !in_vld_q || adv_out;
  assign in_i.ready  = adv_in;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_E4M3;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) fmt_q <= cfg_i.data;
      if (adv_in) in_vld_q <= in_i.valid;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_i.valid) in_q <= in_i.data;
    if (adv_out && in_vld_q) out_q <= res_d;
  end

  // Quantizer.
  logic        q_sign;
  logic [30:0] q_mag, q_cl;
  logic [1:0]  mbits;
  logic [9:0]  q_e;
  logic [22:0] q_mant;
  logic [23:0] q_sub;
  logic [3:0]  q_top;
  logic [4:0]  q_topi;
  logic        q_rnd, q_stk;
  logic [9:0]  q_ee;
  logic [7:0]  q_code;

  always_comb begin
    q_sign = in_q.fp32_in[31];
    q_mag  = in_q.fp32_in[30:0];
    mbits  = (fmt_q == FMT_E4M3) ? 2'd3 : 2'd2;
    q_cl   = q_mag;
    if (fmt_q == FMT_E4M3 && q_mag > E4m3MaxMag) q_cl = E4m3MaxMag;
    if (fmt_q == FMT_E5M2 && q_mag > E5m2MaxMag) q_cl = E5m2MaxMag;
    q_mant = q_cl[22:0];
    q_e    = {2'b00, q_cl[30:23]} - 10'd127
           + ((fmt_q == FMT_E4M3) ? 10'd7 : 10'd15);
    q_sub  = 24'd0;
    q_top  = 4'd0;
    q_rnd  = 1'b0;
    q_stk  = 1'b0;
    q_topi = 5'd0;
    q_ee   = q_e;
    q_code = 8'd0;
    if (q_mag > Fp32InfMag) begin
      q_code = Fp8NanCode;
    end else if (q_mag == Fp32InfMag) begin
      q_code = {q_sign, ((fmt_q == FMT_E4M3) ? E4m3InfCode[6:0] : E5m2InfCode[6:0])};
    end else if (q_mag == 31'd0) begin
      q_code = 8'd0;
    end else if (q_e[9] || q_e == 10'd0) begin
      if ($signed(q_e) < $signed(10'd1) - $signed({8'd0, mbits})) begin
        q_code = {q_sign, 7'd0};
      end else begin
        q_sub = {1'b1, q_mant} >> (10'd1 - q_e);
        q_top = (fmt_q == FMT_E4M3) ? {1'b0, q_sub[22:20]} : {2'b00, q_sub[22:21]};
        q_code = {q_sign, 3'd0, q_top};
      end
    end else begin
      if (fmt_q == FMT_E4M3) begin
        q_top = {1'b0, q_mant[22:20]};
        q_rnd = q_mant[19];
        q_stk = |q_mant[18:0];
      end else begin
        q_top = {2'b00, q_mant[22:21]};
        q_rnd = q_mant[20];
        q_stk = |q_mant[19:0];
      end
      q_topi = {1'b0, q_top};
      if (q_rnd && (q_stk || q_top[0])) q_topi = q_topi + 5'd1;
      if (fmt_q == FMT_E4M3) begin
        if (q_topi[3]) begin
          q_ee = q_e + 10'd1;
          q_topi = 5'd0;
        end
        q_code = {q_sign, q_ee[3:0], q_topi[2:0]};
      end else begin
        if (q_topi[2]) begin
          q_ee = q_e + 10'd1;
          q_topi = 5'd0;
        end
        q_code = {q_sign, q_ee[4:0], q_topi[1:0]};
      end
    end
  end

  // Expander.
  logic [4:0]  x_eb;
  logic [2:0]  x_m;
  logic [7:0]  x_e;
  logic [22:0] x_f;
  logic [31:0] x_res;

  always_comb begin
    if (fmt_q == FMT_E4M3) begin
      x_eb = {1'b0, in_q.fp8_in[6:3]};
      x_m  = in_q.fp8_in[2:0];
    end else begin
      x_eb = in_q.fp8_in[6:2];
      x_m  = {1'b0, in_q.fp8_in[1:0]};
    end
    x_e = 8'd0;
    x_f = 23'd0;
    x_res = 32'd0;
    if (in_q.fp8_in == 8'd0) begin
      x_res = 32'd0;
    end else if (x_eb == 5'd0) begin
      if (x_m == 3'd0) begin
        x_res = {in_q.fp8_in[7], 31'd0};
      end else begin
        // Subnormal: exponent 127 + p + 1 - bias - mbits.
        if (x_m[2]) begin
          x_e = 8'd120;
          x_f = {x_m[1:0], 21'd0};
        end else if (x_m[1]) begin
          x_e = 8'd119;
          x_f = {x_m[0], 22'd0};
        end else begin
          x_e = 8'd118;
          x_f = 23'd0;
        end
        if (fmt_q == FMT_E5M2) x_e = x_e - 8'd7;
        x_res = {in_q.fp8_in[7], x_e, x_f};
      end
    end else begin
      if (fmt_q == FMT_E4M3) begin
        x_e = {3'd0, x_eb} + 8'd120;
        x_f = {x_m, 20'd0};
      end else begin
        x_e = {3'd0, x_eb} + 8'd112;
        x_f = {x_m[1:0], 21'd0};
      end
      x_res = {in_q.fp8_in[7], x_e, x_f};
    end
  end

  always_comb begin
    res_d = '0;
    if (in_q.action == ACT_QUANT) res_d.fp8_out = q_code;
    else res_d.fp32_out = x_res;
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_vld_q && !out_o.ready, out_vld_q && $stable(out_q), "result changed while stalled")
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_vld_q, out_q.fp8_out == 8'd0 || out_q.fp32_out == 32'd0, "both result fields nonzero")
  `ASSERT_NEXT(a_flow, clk_i, rst_ni, in_vld_q && adv_out, out_vld_q, "converted word lost")

endmodule
`default_nettype wire
